// File: src/awfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awfs_pkg
// Shared types and constants of the LED window frame serializer.
// ----------------------------------------------------------------------------
package awfs_pkg;

  localparam int MAX_LEDS  = 64;
  localparam int WINDOW    = 5;
  localparam int LED_AW    = $clog2(MAX_LEDS);
  localparam int SLOT_W    = $clog2(MAX_LEDS + 1);
  localparam int SUM_W     = SLOT_W + 2;
  localparam int PIX_W     = 24;
  localparam int CNT_W     = 7;
  localparam int HDR_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER    = 2'd1;

  localparam logic [CNT_W-1:0] LED_COUNT_RST = 7'd60;
  localparam logic [HDR_W-1:0] HEADER_RST    = 8'h8F;
  localparam logic [31:0]      OFF_WORD      = 32'h8000_0000;

  // classified input item
  typedef struct packed {
    logic              is_tick;
    logic [LED_AW-1:0] idx;
    logic [PIX_W-1:0]  pix;
  } item_t;

  // one serial bit with its tags
  typedef struct packed {
    logic data_bit;
    logic frame_start;
    logic lit_slot;
  } result_t;

  // configuration write beat
  typedef struct packed {
    logic                 en;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
  } cfg_wr_t;

endpackage
`default_nettype wire

// File: src/awfs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awfs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module awfs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: src/awfs_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awfs_front
// Input stage: accepts items, decodes the op and registers the classified item.
// ----------------------------------------------------------------------------
module awfs_front import awfs_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  output      logic              full_o,
  input  wire logic              op_i,
  input  wire logic [LED_AW-1:0] pixel_index_i,
  input  wire logic [7:0]        red_i,
  input  wire logic [7:0]        green_i,
  input  wire logic [7:0]        blue_i,
  output      logic              item_valid_o,
  output      item_t             item_o,
  input  wire logic              item_ready_i
);

  logic  vld_q, vld_d;
  item_t item_q, item_d;
  logic  accept;

  assign full_o = vld_q && !item_ready_i;
  assign accept = push_i && !full_o;

  // classify and hold one beat
  always_comb begin
    vld_d  = accept || (vld_q && !item_ready_i);
    item_d = item_q;
    if (accept) begin
      item_d.is_tick = op_i;
      item_d.idx     = pixel_index_i;
      item_d.pix     = {blue_i, green_i, red_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = vld_q;
  assign item_o       = item_q;

endmodule
`default_nettype wire

// File: src/awfs_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awfs_queue
// Two-entry queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module awfs_queue import awfs_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  wr_valid_i,
  input  wire item_t wr_item_i,
  output      logic  wr_ready_o,
  output      logic  rd_valid_o,
  output      item_t rd_item_o,
  input  wire logic  rd_ready_i
);

  item_t      ent_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       wr_fire, rd_fire;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_item_o  = ent_q[rptr_q];
  assign wr_fire    = wr_valid_i && wr_ready_o;
  assign rd_fire    = rd_valid_o && rd_ready_i;

  // pointer and fill bookkeeping
  always_comb begin
    wptr_d = wptr_q ^ wr_fire;
    rptr_d = rptr_q ^ rd_fire;
    cnt_d  = cnt_q;
    if (wr_fire && !rd_fire) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!wr_fire && rd_fire) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_fire) begin
      ent_q[wptr_q] <= wr_item_i;
    end
  end

endmodule
`default_nettype wire

// File: src/awfs_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awfs_back
// Executes items: pixel writes into the color store, ticks through the frame
// sequencer, results into a two-entry output queue.
// ----------------------------------------------------------------------------
module awfs_back import awfs_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire cfg_wr_t cfg_i,
  input  wire logic    item_valid_i,
  input  wire item_t   item_i,
  output      logic    item_ready_o,
  output      logic    empty_o,
  input  wire logic    pop_i,
  output      result_t res_o
);

  // configuration registers
  logic [CNT_W-1:0] led_count_q;
  logic [HDR_W-1:0] header_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_count_q <= LED_COUNT_RST;
      header_q    <= HEADER_RST;
    end else if (cfg_i.en) begin
      case (cfg_i.index)
        CFG_LED_COUNT: led_count_q <= cfg_i.data[CNT_W-1:0];
        CFG_HEADER:    header_q    <= cfg_i.data[HDR_W-1:0];
        default:       ;
      endcase
    end
  end

  // effective LED count, clamped to the store depth
  logic [SUM_W-1:0] count_w;
  always_comb begin
    if (SUM_W'(led_count_q) > SUM_W'(MAX_LEDS)) begin
      count_w = SUM_W'(MAX_LEDS);
    end else begin
      count_w = SUM_W'(led_count_q);
    end
  end

  // output queue
  result_t    oq_q [2];
  logic       oq_wptr_q, oq_rptr_q;
  logic [1:0] oq_cnt_q, oq_cnt_d;
  logic       oq_push, oq_pop, oq_space;
  result_t    res_d;

  assign empty_o  = (oq_cnt_q == 2'd0);
  assign res_o    = oq_q[oq_rptr_q];
  assign oq_pop   = pop_i && !empty_o;
  assign oq_space = (oq_cnt_q != 2'd2) || oq_pop;

  // item dispatch
  logic take, tick, wr;
  assign take         = item_valid_i && (!item_i.is_tick || oq_space);
  assign item_ready_o = !item_i.is_tick || oq_space;
  assign tick         = take && item_i.is_tick;
  assign wr           = take && !item_i.is_tick;
  assign oq_push      = tick;

  // sequencer state
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [4:0]        bit_q, bit_d;
  logic [SLOT_W-1:0] win_q, win_d;
  logic [31:0]       shift_q, shift_d;

  // color store with per-entry valid bits and same-cycle write bypass
  logic [MAX_LEDS-1:0] vld_q;
  logic [LED_AW-1:0]   raddr;
  logic [PIX_W-1:0]    rdata;
  logic                rvld_q, byp_q;
  logic [PIX_W-1:0]    byp_data_q;
  logic [PIX_W-1:0]    cur_pix;

  awfs_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_LEDS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr),
    .waddr_i (item_i.idx),
    .wdata_i (item_i.pix),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    if (byp_q) begin
      cur_pix = byp_data_q;
    end else if (rvld_q) begin
      cur_pix = rdata;
    end else begin
      cur_pix = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
      byp_q  <= 1'b0;
    end else begin
      if (wr) begin
        vld_q[item_i.idx] <= 1'b1;
      end
      rvld_q <= vld_q[raddr];
      byp_q  <= wr && (item_i.idx == raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= item_i.pix;
  end

  // bit generation and frame stepping
  logic [SUM_W-1:0] led_w, win_w, slot_nx, win_nx;
  logic             lit, first;
  logic [31:0]      word;

  always_comb begin
    led_w   = SUM_W'(slot_q) - SUM_W'(1);
    win_w   = SUM_W'(win_q);
    lit     = (slot_q != '0) && (led_w >= win_w) && (led_w < win_w + SUM_W'(WINDOW));
    first   = (slot_q == '0) && (bit_q == 5'd0);
    word    = shift_q;
    if (bit_q == 5'd0) begin
      if (slot_q == '0) begin
        word = '0;
      end else if (lit) begin
        word = {header_q, cur_pix};
      end else begin
        word = OFF_WORD;
      end
    end
    res_d.data_bit    = word[31];
    res_d.frame_start = first;
    res_d.lit_slot    = lit;

    slot_nx = SUM_W'(slot_q) + SUM_W'(1);
    win_nx  = win_w + SUM_W'(WINDOW);
    slot_d  = slot_q;
    win_d   = win_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    if (tick) begin
      shift_d = {word[30:0], 1'b0};
      bit_d   = bit_q + 5'd1;
      if (bit_q == 5'd31) begin
        if (slot_nx > count_w) begin
          slot_d = '0;
          if (win_nx + SUM_W'(WINDOW - 1) >= count_w) begin
            win_d = '0;
          end else begin
            win_d = win_nx[SLOT_W-1:0];
          end
        end else begin
          slot_d = slot_nx[SLOT_W-1:0];
        end
      end
    end
    // keep the store read aimed at the LED of the next word
    raddr = LED_AW'(slot_d - SLOT_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      bit_q   <= 5'd0;
      win_q   <= '0;
      shift_q <= '0;
    end else begin
      slot_q  <= slot_d;
      bit_q   <= bit_d;
      win_q   <= win_d;
      shift_q <= shift_d;
    end
  end

  // output queue bookkeeping
  always_comb begin
    oq_cnt_d = oq_cnt_q;
    if (oq_push && !oq_pop) begin
      oq_cnt_d = oq_cnt_q + 2'd1;
    end else if (!oq_push && oq_pop) begin
      oq_cnt_d = oq_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wptr_q <= 1'b0;
      oq_rptr_q <= 1'b0;
      oq_cnt_q  <= 2'd0;
    end else begin
      oq_wptr_q <= oq_wptr_q ^ oq_push;
      oq_rptr_q <= oq_rptr_q ^ oq_pop;
      oq_cnt_q  <= oq_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      oq_q[oq_wptr_q] <= res_d;
    end
  end

endmodule
`default_nettype wire

// File: src/apa102_window_frame_serializer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apa102_window_frame_serializer_top
// LED strip frame serializer with a moving five-LED lit window.
//
// Input channel (push/full): op 0 writes a pixel color into the store, op 1
// is one serial clock tick. Each tick beat yields one result beat on the
// output channel (empty/pop): data_bit, frame_start and lit_slot. Pixel
// writes yield nothing.
// Configuration (cfg_valid_i/cfg_ready_o): index 0 is led_count, index 1 is
// header_byte; other indexes are ignored. Write only while idle.
// Throughput: one item per cycle while ticks find room in the output queue,
// set by the back-end sequencer and the single-port color store read.
// Path: after the edge that accepts its beat, a tick result passes the item
// queue and the back-end into the output queue, then shows on the result ports
// and can be popped at the next edge.
// Reset: the color store reads as zero (per-entry valid bits), the frame
// restarts at its start frame and registers take 60 and 0x8F. No clearing
// pass is needed; items are taken from the first cycle after reset.
// Stalls: when pop stays low the two-entry output queue fills, ticks hold in
// the item queue and full rises; pixel writes ahead of the first waiting tick
// still reach the store.
// ----------------------------------------------------------------------------
module apa102_window_frame_serializer_top import awfs_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push,
  output      logic                 full,
  input  wire logic                 op_i,
  input  wire logic [LED_AW-1:0]    pixel_index_i,
  input  wire logic [7:0]           red_i,
  input  wire logic [7:0]           green_i,
  input  wire logic [7:0]           blue_i,
  output      logic                 empty,
  input  wire logic                 pop,
  output      logic                 data_bit_o,
  output      logic                 frame_start_o,
  output      logic                 lit_slot_o,
  input  wire logic                 cfg_valid_i,
  output      logic                 cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i
);

  logic    f_valid, f_ready;
  item_t   f_item;
  logic    q_valid, q_ready;
  item_t   q_item;
  cfg_wr_t cfg;
  result_t res;

  assign cfg_ready_o = 1'b1;
  assign cfg.en      = cfg_valid_i;
  assign cfg.index   = cfg_index_i;
  assign cfg.data    = cfg_data_i;

  awfs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .op_i          (op_i),
    .pixel_index_i (pixel_index_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .item_valid_o  (f_valid),
    .item_o        (f_item),
    .item_ready_i  (f_ready)
  );

  awfs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_item_i  (f_item),
    .wr_ready_o (f_ready),
    .rd_valid_o (q_valid),
    .rd_item_o  (q_item),
    .rd_ready_i (q_ready)
  );

  awfs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_ready_o (q_ready),
    .empty_o      (empty),
    .pop_i        (pop),
    .res_o        (res)
  );

  assign data_bit_o    = res.data_bit;
  assign frame_start_o = res.frame_start;
  assign lit_slot_o    = res.lit_slot;

endmodule
`default_nettype wire

// File: test/awfs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awfs_checker
// Watches the pixel/tick, result and register channels of the LED window
// frame serializer. It keeps its own copy of the color store, frame position,
// moving window and registers, works out the serial bit each tick beat should
// produce and compares every result beat with the oldest expected one.
// ----------------------------------------------------------------------------
module awfs_checker import awfs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  input  logic                 full,
  input  logic                 op_i,
  input  logic [LED_AW-1:0]    pixel_index_i,
  input  logic [7:0]           red_i,
  input  logic [7:0]           green_i,
  input  logic [7:0]           blue_i,
  input  logic                 empty,
  input  logic                 pop,
  input  logic                 data_bit_o,
  input  logic                 frame_start_o,
  input  logic                 lit_slot_o,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output int                   err_count_o,
  output int                   pending_o
);

  // shadow of the serializer state
  logic [PIX_W-1:0] color_mem [MAX_LEDS];
  int               win_base;
  int               slot;
  int               bitpos;
  logic [31:0]      shreg;
  logic [CNT_W-1:0] strip_len;
  logic [HDR_W-1:0] hdr_byte;

  // bits still owed by the block, oldest first
  result_t          owed_bits[$];
  int               beat_no;

  initial begin
    err_count_o = 0;
    pending_o   = 0;
  end

  task automatic report(input string field, input logic want, input logic got);
    $display("mismatch on result beat %0d: %s expected %0b got %0b",
             beat_no, field, want, got);
    err_count_o++;
  endtask

  // one serial clock tick: emit the next bit of the current frame
  task automatic shift_one(output result_t r);
    int  n_leds;
    bit  lit;
    bit  first;
    n_leds = (strip_len > MAX_LEDS) ? MAX_LEDS : int'(strip_len);
    lit    = (slot != 0) && (slot - 1 >= win_base) && (slot - 1 < win_base + WINDOW);
    first  = (slot == 0) && (bitpos == 0);

    // word is fetched on its first bit
    if (bitpos == 0) begin
      if (slot == 0)
        shreg = '0;
      else if (lit && slot - 1 < MAX_LEDS)
        shreg = {hdr_byte, color_mem[slot-1]};
      else
        shreg = OFF_WORD;
    end

    r.data_bit    = shreg[31];
    r.frame_start = first;
    r.lit_slot    = lit;

    shreg  = shreg << 1;
    bitpos = (bitpos + 1) % 32;
    if (bitpos == 0) begin
      slot++;
      if (slot > n_leds) begin
        slot = 0;
        win_base += WINDOW;
        if (win_base + WINDOW - 1 >= n_leds) win_base = 0;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t got;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_LEDS; i++) color_mem[i] = '0;
      win_base  = 0;
      slot      = 0;
      bitpos    = 0;
      shreg     = '0;
      strip_len = LED_COUNT_RST;
      hdr_byte  = HEADER_RST;
      owed_bits.delete();
      beat_no   = 0;
    end else begin
      // result side first, so a beat can never match its own item
      if (pop && !empty) begin
        got = '{data_bit: data_bit_o, frame_start: frame_start_o, lit_slot: lit_slot_o};
        if (owed_bits.size() == 0) begin
          $display("unexpected result beat %0d: %b", beat_no, got);
          err_count_o++;
        end else begin
          want = owed_bits.pop_front();
          if (got.data_bit !== want.data_bit)
            report("data_bit", want.data_bit, got.data_bit);
          if (got.frame_start !== want.frame_start)
            report("frame_start", want.frame_start, got.frame_start);
          if (got.lit_slot !== want.lit_slot)
            report("lit_slot", want.lit_slot, got.lit_slot);
        end
        beat_no++;
      end

      // register writes; unknown indexes fall through
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_LED_COUNT: strip_len = cfg_data_i[CNT_W-1:0];
          CFG_HEADER:    hdr_byte  = cfg_data_i[HDR_W-1:0];
          default: ;
        endcase
      end

      // input side
      if (push && !full) begin
        if (op_i) begin
          shift_one(want);
          owed_bits.push_back(want);
        end else begin
          color_mem[pixel_index_i] = {blue_i, green_i, red_i};
        end
      end
    end
    pending_o = owed_bits.size();
  end

endmodule

// File: test/tb_apa102_window_frame_serializer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_apa102_window_frame_serializer_top
// Drives pixel writes, serial ticks and register writes into the LED window
// frame serializer through several strip lengths and header bytes, with
// random gaps on the sender and stalls on the receiver. Checking is done by
// awfs_checker; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_apa102_window_frame_serializer_top;
  import awfs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 8;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 push          = 1'b0;
  logic                 full;
  logic                 op_i          = 1'b0;
  logic [LED_AW-1:0]    pixel_index_i = '0;
  logic [7:0]           red_i         = '0;
  logic [7:0]           green_i       = '0;
  logic [7:0]           blue_i        = '0;
  logic                 empty;
  logic                 pop           = 1'b0;
  logic                 data_bit_o;
  logic                 frame_start_o;
  logic                 lit_slot_o;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i    = '0;

  int err_count;
  int pending;
  int cycles        = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  apa102_window_frame_serializer_top DUT (
    .clk_i, .rst_ni, .push, .full, .op_i, .pixel_index_i, .red_i, .green_i,
    .blue_i, .empty, .pop, .data_bit_o, .frame_start_o, .lit_slot_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  awfs_checker u_checker (
    .clk_i, .rst_ni, .push, .full, .op_i, .pixel_index_i, .red_i, .green_i,
    .blue_i, .empty, .pop, .data_bit_o, .frame_start_o, .lit_slot_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .err_count_o(err_count), .pending_o(pending)
  );

  // clock
  always #1 clk_i = ~clk_i;

  // receiver: pop with random stalls
  always @(posedge clk_i) begin
    pop <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("FAIL");
      $finish;
    end
  end

  // one input beat, with optional idle cycles ahead of it
  task automatic send_item(input logic op, input logic [LED_AW-1:0] idx,
                           input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b);
    bit took;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push          <= 1'b1;
    op_i          <= op;
    pixel_index_i <= idx;
    red_i         <= r;
    green_i       <= g;
    blue_i        <= b;
    do begin
      @(negedge clk_i);
      took = !full;
      @(posedge clk_i);
    end while (!took);
  endtask

  task automatic tick();
    send_item(1'b1, LED_AW'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // stop sending and let every owed bit come out, plus pipeline slack
  task automatic drain();
    push <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] val);
    bit took;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do begin
      @(negedge clk_i);
      took = cfg_ready_o;
      @(posedge clk_i);
    end while (!took);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // one phase: drain, new settings, idle and stall rates, then random pixel writes and ticks
  task automatic run_phase(input logic [CFG_DAT_W-1:0] len, input logic [7:0] hdr,
                           input int idle_pct, input int stall_pct,
                           input int n_items, input bit hold_mid);
    drain();
    write_reg(CFG_LED_COUNT, len);
    write_reg(CFG_HEADER, hdr);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n_items; i++) begin
      if (hold_mid && i == n_items / 2) drain();
      if ($urandom_range(99) < 75)
        tick();
      else if ($urandom_range(1))
        // mostly LEDs the window visits soon
        send_item(1'b0, LED_AW'($urandom_range(15)), 8'($urandom), 8'($urandom),
                  8'($urandom));
      else
        send_item(1'b0, LED_AW'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: unknown indexes, color extremes, short strip, first ticks
    write_reg(2'd2, 8'hFF);
    write_reg(2'd3, 8'h00);
    write_reg(CFG_LED_COUNT, 8'd5);
    send_item(1'b0, 6'd0,  8'hFF, 8'h00, 8'h00);
    send_item(1'b0, 6'd1,  8'h00, 8'hFF, 8'h00);
    send_item(1'b0, 6'd2,  8'h00, 8'h00, 8'hFF);
    send_item(1'b0, 6'd3,  8'hFF, 8'hFF, 8'hFF);
    send_item(1'b0, 6'd4,  8'hA5, 8'h5A, 8'hC3);
    send_item(1'b0, 6'd63, 8'hFF, 8'hFF, 8'hFF);
    send_item(1'b0, 6'd5,  8'h00, 8'h00, 8'h00);
    repeat (16) tick();

    // random phases; switching from a long strip to a short one mid-frame
    // ends that frame early, zero length sends start frames only
    run_phase(8'd5,           8'h00,        0,  0,  70, 1'b0);
    run_phase(8'hFF,          8'hFF,        75, 0,  70, 1'b0);
    run_phase(8'd3,           8'($urandom), 0,  75, 70, 1'b0);
    run_phase(8'd0,           8'hE0,        18, 18, 70, 1'b0);
    run_phase(8'd10,          8'($urandom), 0,  0,  70, 1'b1);
    run_phase(8'd64,          8'($urandom), 75, 0,  70, 1'b0);
    run_phase(8'd12,          8'($urandom), 0,  75, 70, 1'b0);
    run_phase(8'h87,          8'($urandom), 18, 18, 70, 1'b0);

    drain();
    if (err_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// File: apa102_window_frame_serializer_top.f
src/awfs_pkg.sv
src/awfs_ram.sv
src/awfs_front.sv
src/awfs_queue.sv
src/awfs_back.sv
src/apa102_window_frame_serializer_top.sv
test/awfs_checker.sv
test/tb_apa102_window_frame_serializer_top.sv
